>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the mailbox store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hw/rtl/mmbox_pkg.sv
// Types and constants of the message mailbox store.
package mmbox_pkg;

  localparam int unsigned CFG_BITS = 6;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic {
    CMD_SEND = 1'b0,
    CMD_RECV = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_e;

endpackage

>>> hw/rtl/mmbox_cell.sv
// One message slot of the rotating slot ring.
module mmbox_cell #(
  parameter int unsigned ID_BITS      = 6,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic                    used_i,
  input  logic [ID_BITS-1:0]      dest_i,
  input  logic [ID_BITS-1:0]      src_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    used_o,
  output logic [ID_BITS-1:0]      dest_o,
  output logic [ID_BITS-1:0]      src_o,
  output logic [PAYLOAD_BITS-1:0] payload_o
);

  logic                    used_q;
  logic [ID_BITS-1:0]      dest_q;
  logic [ID_BITS-1:0]      src_q;
  logic [PAYLOAD_BITS-1:0] payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= used_i;
    end
  end

  // Slot contents are only looked at while the used flag is set.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      dest_q    <= dest_i;
      src_q     <= src_i;
      payload_q <= payload_i;
    end
  end

  assign used_o    = used_q;
  assign dest_o    = dest_q;
  assign src_o     = src_q;
  assign payload_o = payload_q;

endmodule

>>> hw/rtl/message_mailbox_store.sv
// A command is taken only while idle; busy is held through its scan, in which the slots sit in
// a ring of cells that rotates once around, one slot a cycle past a single head check. The result
// strobe is registered from the last step of the scan; start may be raised in the strobe cycle.
// Reset clears all used flags, the message count and the interrupt source id (all ones).
`include "assert_macros.svh"

module message_mailbox_store #(
  parameter int unsigned SLOTS        = 64,
  parameter int unsigned ID_BITS      = 6,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command_i,
  input  logic [ID_BITS-1:0]                   thread_id_i,
  input  logic [ID_BITS-1:0]                   peer_id_i,
  input  logic                                 any_source_i,
  input  logic                                 from_interrupt_i,
  input  logic [PAYLOAD_BITS-1:0]              payload_in_i,
  input  logic                                 cfg_we_i,
  input  logic [mmbox_pkg::CFG_BITS-1:0]       cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic [mmbox_pkg::STATUS_BITS-1:0]    status_o,
  output logic [ID_BITS-1:0]                   source_out_o,
  output logic [PAYLOAD_BITS-1:0]              payload_out_o,
  output logic [$clog2(SLOTS+1)-1:0]           stored_count_o
);

  import mmbox_pkg::*;

  localparam int unsigned STEP_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SLOTS - 1);

  fsm_e state_q, state_d;
  logic shift_en, last_step;

  logic [STEP_W-1:0]        step_q, step_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CFG_BITS-1:0]      irq_src_q;

  cmd_e                     cmd_q;
  logic [ID_BITS-1:0]       thread_q, peer_q, send_src_q;
  logic                     any_q;
  logic [PAYLOAD_BITS-1:0]  pay_q;
  logic                     found_q, found_d;
  logic [ID_BITS-1:0]       rsrc_q, rsrc_d;
  logic [PAYLOAD_BITS-1:0]  rpay_q, rpay_d;

  logic                     valid_q;
  logic [STATUS_BITS-1:0]   status_q;
  logic [ID_BITS-1:0]       src_out_q;
  logic [PAYLOAD_BITS-1:0]  pay_out_q;

  logic                     cell_used [SLOTS];
  logic [ID_BITS-1:0]       cell_dest [SLOTS];
  logic [ID_BITS-1:0]       cell_src  [SLOTS];
  logic [PAYLOAD_BITS-1:0]  cell_pay  [SLOTS];

  logic                     ring_used;
  logic [ID_BITS-1:0]       ring_dest, ring_src;
  logic [PAYLOAD_BITS-1:0]  ring_pay;
  logic                     send_hit, recv_hit;

  logic accept;
  assign accept = start && !busy;

  // Slot ring: each cell takes its upper neighbor; the top cell takes the head after the check.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_top
      mmbox_cell #(.ID_BITS(ID_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (shift_en),
        .used_i    (ring_used),
        .dest_i    (ring_dest),
        .src_i     (ring_src),
        .payload_i (ring_pay),
        .used_o    (cell_used[i]),
        .dest_o    (cell_dest[i]),
        .src_o     (cell_src[i]),
        .payload_o (cell_pay[i])
      );
    end else begin : g_mid
      mmbox_cell #(.ID_BITS(ID_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .shift_i   (shift_en),
        .used_i    (cell_used[i+1]),
        .dest_i    (cell_dest[i+1]),
        .src_i     (cell_src[i+1]),
        .payload_i (cell_pay[i+1]),
        .used_o    (cell_used[i]),
        .dest_o    (cell_dest[i]),
        .src_o     (cell_src[i]),
        .payload_o (cell_pay[i])
      );
    end
  end

  // Head check: the first qualifying slot in index order is claimed or freed.
  always_comb begin
    send_hit = (cmd_q == CMD_SEND) && !cell_used[0] && !found_q;
    recv_hit = (cmd_q == CMD_RECV) && cell_used[0] && !found_q &&
               (cell_dest[0] == thread_q) && (any_q || (cell_src[0] == peer_q));
    ring_used = send_hit ? 1'b1 : (recv_hit ? 1'b0 : cell_used[0]);
    ring_dest = send_hit ? peer_q     : cell_dest[0];
    ring_src  = send_hit ? send_src_q : cell_src[0];
    ring_pay  = send_hit ? pay_q      : cell_pay[0];
    found_d   = found_q || send_hit || recv_hit;
    rsrc_d    = recv_hit ? cell_src[0] : rsrc_q;
    rpay_d    = recv_hit ? cell_pay[0] : rpay_q;
  end

  assign last_step = (step_q == LAST_STEP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (accept) state_d = FSM_SCAN;
      FSM_SCAN: if (last_step) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    shift_en = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        busy = 1'b0;
      end
      FSM_SCAN: begin
        busy     = 1'b1;
        shift_en = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_d  = shift_en ? (last_step ? '0 : step_q + STEP_W'(1)) : step_q;
    count_d = count_q;
    if (shift_en && last_step) begin
      if (cmd_q == CMD_SEND && found_d) begin
        count_d = count_q + CNT_W'(1);
      end else if (cmd_q == CMD_RECV && found_d && count_q != '0) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      step_q    <= '0;
      count_q   <= '0;
      irq_src_q <= '1;
      found_q   <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      valid_q <= shift_en && last_step;
      if (cfg_we_i) begin
        irq_src_q <= cfg_wdata_i;
      end
      if (accept) begin
        found_q <= 1'b0;
      end else if (shift_en) begin
        found_q <= found_d;
      end
    end
  end

  // Command beat and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(command_i);
      thread_q   <= thread_id_i;
      peer_q     <= peer_id_i;
      any_q      <= any_source_i;
      pay_q      <= payload_in_i;
      send_src_q <= from_interrupt_i ? ID_BITS'(irq_src_q) : thread_id_i;
      rsrc_q     <= '0;
      rpay_q     <= '0;
    end else if (shift_en) begin
      rsrc_q <= rsrc_d;
      rpay_q <= rpay_d;
    end
    if (shift_en && last_step) begin
      if (found_d) begin
        status_q <= ST_OK;
      end else if (cmd_q == CMD_SEND) begin
        status_q <= ST_FULL;
      end else begin
        status_q <= ST_NOMATCH;
      end
      src_out_q <= rsrc_d;
      pay_out_q <= rpay_d;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign source_out_o   = src_out_q;
  assign payload_out_o  = pay_out_q;
  assign stored_count_o = count_q;

  `ASSERT_CLK(a_result_when_idle, clk_i, rst_ni, result_valid_o |-> !busy, "result strobe while busy")
  `ASSERT_CLK(a_start_makes_busy, clk_i, rst_ni, accept |=> busy, "accepted command did not start a scan")
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(SLOTS), "message count above slot count")
  `ASSERT_CLK(a_full_means_all_used, clk_i, rst_ni, (result_valid_o && status_o == ST_FULL) |-> (stored_count_o == CNT_W'(SLOTS)), "store full reported with free slots")

endmodule
